// ===== src/rbu_pkg.sv =====
// rbu_pkg: shared widths, constants and the arctangent table of the bearing unit
// no dependencies; imported by every module of the block

package rbu_pkg;

   localparam int COORD_WIDTH     = 16;
   localparam int ANGLE_FRAC_BITS = 13;
   localparam int CORDIC_STEPS    = 16;

   localparam int ANGLE_W     = 16;
   localparam int GUARD_SHIFT = 60 - COORD_WIDTH;
   localparam int DIFF_W      = COORD_WIDTH + 1;
   localparam int VEC_W       = 64;
   localparam int Z_W         = 36;
   localparam int RND_SH      = 32 - ANGLE_FRAC_BITS;
   localparam int RND_W       = Z_W - RND_SH;
   localparam int SUM_W       = RND_W + 2;
   localparam int STEP_W      = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

   localparam longint PI_Q32 = 64'sd13493037705;
   localparam longint PI_F   = (PI_Q32 + (64'sd1 <<< (RND_SH - 1))) >>> RND_SH;

   localparam logic signed [Z_W-1:0]   PI_Z      = Z_W'(PI_Q32);
   localparam logic signed [Z_W-1:0]   RND_HALF  = Z_W'(64'sd1 <<< (RND_SH - 1));
   localparam logic signed [SUM_W-1:0] PI_S      = SUM_W'(PI_F);
   localparam logic signed [SUM_W-1:0] TWO_PI_S  = SUM_W'(2 * PI_F);

   typedef struct packed {
      logic signed [VEC_W-1:0]   x;
      logic signed [VEC_W-1:0]   y;
      logic signed [Z_W-1:0]     z;
      logic signed [ANGLE_W-1:0] heading;
      logic                      zero;
   } rbu_lane_type;

   function automatic logic signed [Z_W-1:0] atan_q32(input logic [STEP_W-1:0] idx);
      logic signed [Z_W-1:0] r;
      case (idx)
         0:       r = Z_W'(64'sd3373259426);
         1:       r = Z_W'(64'sd1991351318);
         2:       r = Z_W'(64'sd1052175346);
         3:       r = Z_W'(64'sd534100635);
         4:       r = Z_W'(64'sd268086748);
         5:       r = Z_W'(64'sd134174063);
         6:       r = Z_W'(64'sd67103403);
         7:       r = Z_W'(64'sd33553749);
         8:       r = Z_W'(64'sd16777131);
         9:       r = Z_W'(64'sd8388597);
         10:      r = Z_W'(64'sd4194303);
         default: r = (32'(idx) < 32) ? Z_W'(64'sd1 <<< (32 - 32'(idx))) : '0;
      endcase
      return r;
   endfunction

endpackage

// ===== src/relative_bearing_unit.sv =====
// relative_bearing_unit: top level, entry stage, a row of CORDIC cells and the exit stage
// depends on rbu_pkg, rbu_prep, rbu_cell, rbu_wrap
//
// usage
//  - req channel: one beat carries focal point, focal heading and neighbor point
//  - rsp channel: one beat carries the bearing of the neighbor relative to the heading,
//    signed radians Q3.13, wrapped to [-pi, pi); coincident points give the wrapped
//    negated heading
//  - registers from req beat to rsp_valid: one entry stage, one register per cell of the
//    rotation row, one exit stage
//  - throughput: one beat per cycle unless rsp stalls; each stage holds one item
//  - each stage has its own valid bit; a stage takes a new item when it is empty or
//    its successor takes its item, so bubbles close up while rsp is stalled
//  - when the receiver stalls, the result holds in the exit register and req_ready
//    drops once all stages are full; nothing is lost or repeated
//  - reset clears all valid bits; the block keeps no other state

module relative_bearing_unit (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic signed [rbu_pkg::COORD_WIDTH-1:0] req_focal_x,
   input  logic signed [rbu_pkg::COORD_WIDTH-1:0] req_focal_y,
   input  logic signed [rbu_pkg::ANGLE_W-1:0]     req_focal_heading,
   input  logic signed [rbu_pkg::COORD_WIDTH-1:0] req_neighbor_x,
   input  logic signed [rbu_pkg::COORD_WIDTH-1:0] req_neighbor_y,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [rbu_pkg::ANGLE_W-1:0]     rsp_bearing
);
   import rbu_pkg::*;

   logic         stg_valid [CORDIC_STEPS+1];
   logic         stg_ready [CORDIC_STEPS+1];
   rbu_lane_type stg_lane  [CORDIC_STEPS+1];

   rbu_prep u_prep (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (req_valid),
      .in_ready      (req_ready),
      .focal_x       (req_focal_x),
      .focal_y       (req_focal_y),
      .focal_heading (req_focal_heading),
      .neighbor_x    (req_neighbor_x),
      .neighbor_y    (req_neighbor_y),
      .out_valid     (stg_valid[0]),
      .out_ready     (stg_ready[0]),
      .out_lane      (stg_lane[0])
   );

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
      rbu_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .step_idx  (STEP_W'(i)),
         .in_valid  (stg_valid[i]),
         .in_ready  (stg_ready[i]),
         .in_lane   (stg_lane[i]),
         .out_valid (stg_valid[i+1]),
         .out_ready (stg_ready[i+1]),
         .out_lane  (stg_lane[i+1])
      );
   end

   rbu_wrap u_wrap (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (stg_valid[CORDIC_STEPS]),
      .in_ready    (stg_ready[CORDIC_STEPS]),
      .in_lane     (stg_lane[CORDIC_STEPS]),
      .out_valid   (rsp_valid),
      .out_ready   (rsp_ready),
      .out_bearing (rsp_bearing)
   );

endmodule

// ===== src/rbu_prep.sv =====
// rbu_prep: entry stage, forms the difference vector, scales it and folds the left half plane
// depends on rbu_pkg

module rbu_prep (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               in_valid,
   output logic                               in_ready,
   input  logic signed [rbu_pkg::COORD_WIDTH-1:0] focal_x,
   input  logic signed [rbu_pkg::COORD_WIDTH-1:0] focal_y,
   input  logic signed [rbu_pkg::ANGLE_W-1:0]     focal_heading,
   input  logic signed [rbu_pkg::COORD_WIDTH-1:0] neighbor_x,
   input  logic signed [rbu_pkg::COORD_WIDTH-1:0] neighbor_y,
   output logic                               out_valid,
   input  logic                               out_ready,
   output rbu_pkg::rbu_lane_type              out_lane
);
   import rbu_pkg::*;

   logic signed [DIFF_W-1:0] dx;
   logic signed [DIFF_W-1:0] dy;
   logic signed [VEC_W-1:0]  xs;
   logic signed [VEC_W-1:0]  ys;
   rbu_lane_type             lane_in;
   rbu_lane_type             lane_ff;
   logic                     valid_ff;
   logic                     valid_in;

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_comb begin
      dx = DIFF_W'(neighbor_x) - DIFF_W'(focal_x);
      dy = DIFF_W'(neighbor_y) - DIFF_W'(focal_y);
      xs = VEC_W'(dx) <<< GUARD_SHIFT;
      ys = VEC_W'(dy) <<< GUARD_SHIFT;
      lane_in.heading = focal_heading;
      lane_in.zero    = (dx == '0) && (dy == '0);
      if (dx < 0) begin
         lane_in.x = -xs;
         lane_in.y = -ys;
         lane_in.z = (dy >= 0) ? PI_Z : -PI_Z;
      end else begin
         lane_in.x = xs;
         lane_in.y = ys;
         lane_in.z = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         lane_ff <= lane_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_lane  = lane_ff;

endmodule

// ===== src/rbu_cell.sv =====
// rbu_cell: one vectoring micro-rotation with its own stage register
// depends on rbu_pkg

module rbu_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [rbu_pkg::STEP_W-1:0]    step_idx,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  rbu_pkg::rbu_lane_type         in_lane,
   output logic                          out_valid,
   input  logic                          out_ready,
   output rbu_pkg::rbu_lane_type         out_lane
);
   import rbu_pkg::*;

   logic signed [VEC_W-1:0] xsh;
   logic signed [VEC_W-1:0] ysh;
   logic signed [Z_W-1:0]   ang;
   rbu_lane_type            lane_in;
   rbu_lane_type            lane_ff;
   logic                    valid_ff;
   logic                    valid_in;

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_comb begin
      xsh     = in_lane.x >>> step_idx;
      ysh     = in_lane.y >>> step_idx;
      ang     = atan_q32(step_idx);
      lane_in = in_lane;
      if (in_lane.y > 0) begin
         lane_in.x = in_lane.x + ysh;
         lane_in.y = in_lane.y - xsh;
         lane_in.z = in_lane.z + ang;
      end else begin
         lane_in.x = in_lane.x - ysh;
         lane_in.y = in_lane.y + xsh;
         lane_in.z = in_lane.z - ang;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         lane_ff <= lane_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_lane  = lane_ff;

endmodule

// ===== src/rbu_wrap.sv =====
// rbu_wrap: exit stage, rounds the angle, subtracts the heading, wraps to one turn
// depends on rbu_pkg; its register is the result register of the block

module rbu_wrap (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               in_valid,
   output logic                               in_ready,
   input  rbu_pkg::rbu_lane_type              in_lane,
   output logic                               out_valid,
   input  logic                               out_ready,
   output logic signed [rbu_pkg::ANGLE_W-1:0] out_bearing
);
   import rbu_pkg::*;

   logic signed [Z_W-1:0]     zr;
   logic signed [RND_W-1:0]   ang;
   logic signed [SUM_W-1:0]   diff;
   logic signed [SUM_W-1:0]   wrapped;
   logic signed [ANGLE_W-1:0] bearing_in;
   logic signed [ANGLE_W-1:0] bearing_ff;
   logic                      valid_ff;
   logic                      valid_in;

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_comb begin
      zr   = (in_lane.z + RND_HALF) >>> RND_SH;
      ang  = in_lane.zero ? '0 : zr[RND_W-1:0];
      diff = SUM_W'(ang) - SUM_W'(in_lane.heading);
      if (diff >= PI_S) begin
         wrapped = diff - TWO_PI_S;
      end else if (diff < -PI_S) begin
         wrapped = diff + TWO_PI_S;
      end else begin
         wrapped = diff;
      end
      bearing_in = wrapped[ANGLE_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         bearing_ff <= bearing_in;
      end
   end

   assign out_valid   = valid_ff;
   assign out_bearing = bearing_ff;

endmodule

// ===== src/rbu_checker.sv =====
// rbu_checker: port-level checks of the bearing unit, attached to the top level by bind
// depends on rbu_pkg and relative_bearing_unit

module rbu_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_ready,
   input  logic                               rsp_valid,
   input  logic                               rsp_ready,
   input  logic signed [rbu_pkg::ANGLE_W-1:0] rsp_bearing
);
   import rbu_pkg::*;

   // stalled result beat stays up
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp beat dropped while stalled");

   // stalled result beat keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_bearing))
      else $error("rsp payload changed while stalled");

   // reset empties the whole row
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("pipeline not empty after reset");

   // result always wrapped into one turn
   a_bearing_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (32'(rsp_bearing) >= -32'(PI_F)) && (32'(rsp_bearing) < 32'(PI_F)))
      else $error("bearing outside [-pi, pi)");

endmodule

bind relative_bearing_unit rbu_checker u_rbu_checker (.*);

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// testbench for relative_bearing_unit: drives focal/neighbor beats, predicts each bearing
// with a CORDIC atan2 model of its own and checks every rsp beat in order; depends on rbu_pkg

module testbench;

   localparam int CW             = rbu_pkg::COORD_WIDTH;
   localparam int AW             = rbu_pkg::ANGLE_W;
   localparam int STEPS          = rbu_pkg::CORDIC_STEPS;
   localparam int VEC_SHIFT      = 60 - CW;
   localparam int FRAC_SHIFT     = 32 - rbu_pkg::ANGLE_FRAC_BITS;
   localparam longint PI_Z32     = 64'sd13493037705;
   localparam longint HALF_TURN  = (PI_Z32 + (64'sd1 <<< (FRAC_SHIFT - 1))) >>> FRAC_SHIFT;
   localparam int LATENCY        = STEPS + 2;
   localparam int SQUEEZE_CYCLES = 120;
   localparam int RANDOM_ITEMS   = 1850;
   localparam int CYCLE_LIMIT    = 900000;

   typedef struct {
      logic signed [CW-1:0] fx;
      logic signed [CW-1:0] fy;
      logic signed [AW-1:0] hd;
      logic signed [CW-1:0] nx;
      logic signed [CW-1:0] ny;
      logic signed [AW-1:0] bearing;
   } bearing_rec_type;

   logic                 clock             = 1'b0;
   logic                 reset             = 1'b1;
   logic                 req_valid         = 1'b0;
   logic                 req_ready;
   logic signed [CW-1:0] req_focal_x       = '0;
   logic signed [CW-1:0] req_focal_y       = '0;
   logic signed [AW-1:0] req_focal_heading = '0;
   logic signed [CW-1:0] req_neighbor_x    = '0;
   logic signed [CW-1:0] req_neighbor_y    = '0;
   logic                 rsp_valid;
   logic                 rsp_ready         = 1'b0;
   logic signed [AW-1:0] rsp_bearing;

   bearing_rec_type pending_bearings[$];
   bearing_rec_type oldest_bearing;
   int              mismatch_count = 0;
   int              cycle_count    = 0;
   int              squeeze_count  = 0;
   int              squeeze_seen   = 0;
   int              stall_left     = 0;
   logic            back_to_back   = 1'b0;

   relative_bearing_unit u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_focal_x       (req_focal_x),
      .req_focal_y       (req_focal_y),
      .req_focal_heading (req_focal_heading),
      .req_neighbor_x    (req_neighbor_x),
      .req_neighbor_y    (req_neighbor_y),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_bearing       (rsp_bearing)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic longint atan_step(input int k);
      case (k)
         0:  return 64'sd3373259426;
         1:  return 64'sd1991351318;
         2:  return 64'sd1052175346;
         3:  return 64'sd534100635;
         4:  return 64'sd268086748;
         5:  return 64'sd134174063;
         6:  return 64'sd67103403;
         7:  return 64'sd33553749;
         8:  return 64'sd16777131;
         9:  return 64'sd8388597;
         10: return 64'sd4194303;
         default: return (k < 32) ? (64'sd1 <<< (32 - k)) : 64'sd0;
      endcase
   endfunction

   function automatic logic signed [AW-1:0] predict_bearing(
      input logic signed [CW-1:0] fx,
      input logic signed [CW-1:0] fy,
      input logic signed [AW-1:0] hd,
      input logic signed [CW-1:0] nx,
      input logic signed [CW-1:0] ny
   );
      longint dx, dy, vx, vy, sx, sy, acc, ang, diff;
      dx  = longint'(nx) - longint'(fx);
      dy  = longint'(ny) - longint'(fy);
      acc = 0;
      if (dx == 0 && dy == 0) begin
         ang = 0;
      end else begin
         vx = dx * (64'sd1 <<< VEC_SHIFT);
         vy = dy * (64'sd1 <<< VEC_SHIFT);
         if (dx < 0) begin
            vx  = -vx;
            vy  = -vy;
            acc = (dy >= 0) ? PI_Z32 : -PI_Z32;
         end
         for (int k = 0; k < STEPS; k++) begin
            sx = vx >>> k;
            sy = vy >>> k;
            if (vy > 0) begin
               vx  = vx + sy;
               vy  = vy - sx;
               acc = acc + atan_step(k);
            end else begin
               vx  = vx - sy;
               vy  = vy + sx;
               acc = acc - atan_step(k);
            end
         end
         ang = (acc + (64'sd1 <<< (FRAC_SHIFT - 1))) >>> FRAC_SHIFT;
      end
      diff = ang - longint'(hd);
      while (diff >= HALF_TURN) diff = diff - 2 * HALF_TURN;
      while (diff < -HALF_TURN) diff = diff + 2 * HALF_TURN;
      return diff[AW-1:0];
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 50);
   endfunction

   function automatic logic signed [CW-1:0] pick_edge_coord();
      case ($urandom_range(0, 6))
         0:       return CW'(-(2 ** (CW - 1)));
         1:       return CW'(-(2 ** (CW - 1)) + 1);
         2:       return CW'(-1);
         3:       return CW'(0);
         4:       return CW'(1);
         5:       return CW'((2 ** (CW - 1)) - 2);
         default: return CW'((2 ** (CW - 1)) - 1);
      endcase
   endfunction

   function automatic logic signed [AW-1:0] pick_heading();
      int r;
      r = $urandom_range(0, 99);
      if (r < 80) return AW'(int'($urandom_range(0, 2 * HALF_TURN)) - int'(HALF_TURN));
      if (r < 85) return AW'(HALF_TURN);
      if (r < 90) return AW'(-HALF_TURN);
      return AW'($urandom);
   endfunction

   task automatic send_item(
      input logic signed [CW-1:0] fx,
      input logic signed [CW-1:0] fy,
      input logic signed [AW-1:0] hd,
      input logic signed [CW-1:0] nx,
      input logic signed [CW-1:0] ny
   );
      bearing_rec_type rec;
      int              gap;
      req_focal_x       <= fx;
      req_focal_y       <= fy;
      req_focal_heading <= hd;
      req_neighbor_x    <= nx;
      req_neighbor_y    <= ny;
      req_valid         <= 1'b1;
      do @(posedge clock); while (req_ready !== 1'b1);
      rec.fx      = fx;
      rec.fy      = fy;
      rec.hd      = hd;
      rec.nx      = nx;
      rec.ny      = ny;
      rec.bearing = predict_bearing(fx, fy, hd, nx, ny);
      pending_bearings.push_back(rec);
      gap = back_to_back ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain_pending();
      req_valid <= 1'b0;
      while (pending_bearings.size() != 0) @(posedge clock);
   endtask

   task automatic test_directed();
      // coincident points, heading extremes and the half turn
      send_item(100, -200, 0, 100, -200);
      send_item(100, -200, AW'(-HALF_TURN), 100, -200);
      send_item(-5, 7, AW'(HALF_TURN), -5, 7);
      send_item(0, 0, -16'sd32768, 0, 0);
      send_item(0, 0, 16'sd32767, 0, 0);
      send_item(0, 0, AW'(-HALF_TURN), 1, 0);
      // widest differences on each axis and diagonal
      send_item(-16'sd32768, 0, 0, 16'sd32767, 0);
      send_item(16'sd32767, 0, 0, -16'sd32768, 0);
      send_item(16'sd32767, 1, 0, -16'sd32768, 0);
      send_item(0, -16'sd32768, 0, 0, 16'sd32767);
      send_item(0, 16'sd32767, 0, 0, -16'sd32768);
      send_item(-16'sd32768, -16'sd32768, 0, 16'sd32767, 16'sd32767);
      send_item(16'sd32767, 16'sd32767, 0, -16'sd32768, -16'sd32768);
      send_item(16'sd32767, -16'sd32768, 0, -16'sd32768, 16'sd32767);
      send_item(-16'sd32768, 16'sd32767, 0, 16'sd32767, -16'sd32768);
      // left half plane entry on both sides of the axis, plus points on the y axis and right of it
      send_item(0, 0, 0, -1, 0);
      send_item(0, 0, 0, -1, -1);
      send_item(0, 0, 16'sd32767, -1, 0);
      send_item(0, 0, -16'sd32768, 1, -1);
      send_item(0, 0, 0, 0, 1);
      send_item(0, 0, 0, 0, -1);
      send_item(3, 3, AW'(HALF_TURN), 2, 2);
   endtask

   task automatic test_backpressure();
      drain_pending();
      back_to_back = 1'b1;
      squeeze_count++;
      for (int n = 0; n < 3 * LATENCY; n++)
         send_item(CW'($urandom), CW'($urandom), pick_heading(), CW'($urandom), CW'($urandom));
      drain_pending();
      back_to_back = 1'b0;
   endtask

   task automatic test_random();
      logic signed [CW-1:0] fx, fy, nx, ny;
      int                   r, off_x, off_y, d;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 150 == 0) begin
            back_to_back = ($urandom_range(0, 2) == 0);
         end
         fx = CW'($urandom);
         fy = CW'($urandom);
         nx = CW'($urandom);
         ny = CW'($urandom);
         r  = $urandom_range(0, 99);
         if (r >= 45 && r < 70) begin
            off_x = int'($urandom_range(0, 128)) - 64;
            off_y = int'($urandom_range(0, 128)) - 64;
            nx    = CW'(fx + off_x);
            ny    = CW'(fy + off_y);
         end else if (r >= 70 && r < 80) begin
            d = $urandom_range(0, 300);
            case ($urandom_range(0, 3))
               0:       nx = fx;
               1:       ny = fy;
               2:       begin nx = CW'(fx + d); ny = CW'(fy + d); end
               default: begin nx = CW'(fx - d); ny = CW'(fy + d); end
            endcase
         end else if (r >= 80 && r < 85) begin
            nx = fx;
            ny = fy;
         end else if (r >= 85) begin
            fx = pick_edge_coord();
            fy = pick_edge_coord();
            nx = pick_edge_coord();
            ny = pick_edge_coord();
         end
         send_item(fx, fy, pick_heading(), nx, ny);
      end
      back_to_back = 1'b0;
   endtask

   // receiver: random stalls, plus one long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (squeeze_seen != squeeze_count) begin
         squeeze_seen = squeeze_count;
         stall_left   = SQUEEZE_CYCLES;
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left = stall_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         if (!back_to_back && $urandom_range(0, 2) == 0) stall_left = pick_gap();
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
         if (pending_bearings.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected rsp beat, expected none, actual bearing %0d",
                     $time, rsp_bearing);
         end else begin
            oldest_bearing = pending_bearings.pop_front();
            if (rsp_bearing !== oldest_bearing.bearing) begin
               mismatch_count++;
               $display("%0t: bearing expected %0d, actual %0d (focal %0d,%0d hd %0d nbr %0d,%0d)",
                        $time, oldest_bearing.bearing, rsp_bearing, oldest_bearing.fx,
                        oldest_bearing.fy, oldest_bearing.hd, oldest_bearing.nx,
                        oldest_bearing.ny);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_backpressure();
      test_random();
      drain_pending();
      repeat (2 * LATENCY) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
